### hdl/ils_pkg.sv
// types, codes and defaults shared by the indexed list store
package ils_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam logic [2:0] OP_READ     = 3'd0;
    localparam logic [2:0] OP_INS_HEAD = 3'd1;
    localparam logic [2:0] OP_APPEND   = 3'd2;
    localparam logic [2:0] OP_INS_POS  = 3'd3;
    localparam logic [2:0] OP_DELETE   = 3'd4;

    typedef struct packed {
        logic [2:0]          op;
        logic signed [15:0]  position;
        logic signed [31:0]  word_in;
    } t_req;

    typedef struct packed {
        logic signed [31:0]  read_word;
        logic                found;
        logic                applied;
        logic                full_reject;
        logic [10:0]         length_now;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RDWAIT,
        S_SHIFT,
        S_DONE
    } t_state;

endpackage

### hdl/indexed_list_store.sv
// indexed list store: packed word list in memory with positional insert and delete
//
// Input channel i_valid / o_stall carries one request beat (t_req); the output
// channel o_valid / i_stall carries one response beat (t_rsp) per request.
// A request is taken only while the sequencer is idle; o_stall is high while
// a request is in work.
// Steps from accept to response register: a read passes S_RDWAIT, then S_DONE;
// an invalid or rejected request goes straight to S_DONE. An append or insert at
// the tail writes its word in S_SHIFT; a positional insert or delete first moves
// the N words behind the position there (N up to CAPACITY - 1), an insert then
// writes its word, and each ends in S_DONE. The list memory has one read and one
// write port; the shift streams one word per cycle through them.
// With a free receiver the next request is taken in the cycle after the response
// register loads, so each request is finished before the next one is taken.
// The response sits in an output register, so the next request is taken while
// a finished response still waits; a stalled receiver only holds back the
// completion of the following request.
// Reset empties the list at once (length zero); the memory is not cleared and
// entries beyond the length are never read.
module indexed_list_store #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ils_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output ils_pkg::t_rsp o_rsp
);
    import ils_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = 16;

    logic [31:0] mem [CAPACITY];

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_left, n_left;
    logic [AW-1:0]   r_rd_addr, n_rd_addr;
    logic [AW-1:0]   r_raddr_d, n_raddr_d;
    logic            r_rvalid, n_rvalid;
    logic [AW-1:0]   r_at, n_at;
    logic [31:0]     r_word, n_word;
    logic            r_up, n_up;
    logic            r_ins, n_ins;
    t_rsp            r_rsp, n_rsp;
    t_rsp            r_out, n_out;
    logic            r_out_valid, n_out_valid;
    logic [31:0]     r_rdata;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [31:0]     mem_wdata;
    logic [AW-1:0]   mem_raddr;

    logic [CMPW-1:0] pos16;
    logic [CMPW-1:0] cnt16;
    logic            pos_ok;
    logic            pos_le;
    logic            ins_req;
    logic            full;
    logic [CW-1:0]   ins_at;

    assign pos16  = CMPW'(i_req.position);
    assign cnt16  = CMPW'(r_count);
    assign pos_ok = !pos16[CMPW-1] && (pos16 < cnt16);
    assign pos_le = pos16[CMPW-1] || (pos16 <= cnt16);
    assign full   = (r_count == CW'(CAPACITY));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_rd_addr   = r_rd_addr;
        n_raddr_d   = r_raddr_d;
        n_rvalid    = 1'b0;
        n_at        = r_at;
        n_word      = r_word;
        n_up        = r_up;
        n_ins       = r_ins;
        n_rsp       = r_rsp;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = r_at;
        mem_wdata   = r_word;
        mem_raddr   = r_rd_addr;
        ins_req     = 1'b0;
        ins_at      = '0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_rsp  = '0;
                    n_word = i_req.word_in;
                    n_state = S_DONE;
                    case (i_req.op) inside
                        OP_READ: begin
                            if (pos_ok) begin
                                mem_raddr       = AW'(pos16);
                                n_rsp.found     = 1'b1;
                                n_state         = S_RDWAIT;
                            end else begin
                                n_rsp.read_word = '1;
                            end
                        end
                        OP_INS_HEAD, OP_APPEND, OP_INS_POS: begin
                            if (i_req.op == OP_INS_HEAD) begin
                                ins_req = 1'b1;
                                ins_at  = '0;
                            end else if (i_req.op == OP_APPEND) begin
                                ins_req = 1'b1;
                                ins_at  = r_count;
                            end else begin
                                ins_req = pos_le;
                                ins_at  = pos16[CMPW-1] ? '0 : CW'(pos16);
                            end
                            if (ins_req) begin
                                if (full) begin
                                    n_rsp.full_reject = 1'b1;
                                end else begin
                                    n_rsp.applied = 1'b1;
                                    n_count       = r_count + CW'(1);
                                    n_at          = AW'(ins_at);
                                    n_left        = r_count - ins_at;
                                    n_rd_addr     = AW'(r_count - CW'(1));
                                    n_up          = 1'b0;
                                    n_ins         = 1'b1;
                                    n_state       = S_SHIFT;
                                end
                            end
                        end
                        OP_DELETE: begin
                            if (pos_ok) begin
                                n_rsp.applied = 1'b1;
                                n_count       = r_count - CW'(1);
                                n_left        = r_count - CW'(1) - CW'(pos16);
                                n_rd_addr     = AW'(CW'(pos16) + CW'(1));
                                n_up          = 1'b1;
                                n_ins         = 1'b0;
                                n_state       = S_SHIFT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                n_rsp.read_word = r_rdata;
                n_state         = S_DONE;
            end
            S_SHIFT: begin
                if (r_rvalid) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_up ? (r_raddr_d - AW'(1)) : (r_raddr_d + AW'(1));
                    mem_wdata = r_rdata;
                end
                if (r_left != '0) begin
                    mem_raddr = r_rd_addr;
                    n_rvalid  = 1'b1;
                    n_raddr_d = r_rd_addr;
                    n_rd_addr = r_up ? (r_rd_addr + AW'(1)) : (r_rd_addr - AW'(1));
                    n_left    = r_left - CW'(1);
                end else if (!r_rvalid) begin
                    if (r_ins) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_at;
                        mem_wdata = r_word;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out            = r_rsp;
                    n_out.length_now = 11'(r_count);
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // list memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_rvalid    <= n_rvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_raddr_d <= n_raddr_d;
        r_at      <= n_at;
        r_word    <= n_word;
        r_up      <= n_up;
        r_ins     <= n_ins;
        r_rsp     <= n_rsp;
        r_out     <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

### dv/indexed_list_store_tb.sv
`timescale 1ns / 100ps
// testbench for the indexed list store: directed and random requests checked against a list model
module indexed_list_store_tb;
    import ils_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;
    localparam int MAX_WAIT = 15;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam logic signed [31:0] MISSING_WORD = -32'sd1;
    localparam int POS_MIN = -32768;
    localparam int POS_MAX = 32767;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;

    logic signed [31:0] list_words[$];
    t_rsp rsp_due[$];
    int mismatch_count = 0;
    int rx_hold = 0;
    bit no_idle = 1'b0;

    indexed_list_store dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(100_000_000);
        $display("FAIL");
        $finish;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic t_req make_req(input logic [2:0] op, input int pos,
                                      input logic signed [31:0] word);
        t_req req;
        req.op       = op;
        req.position = 16'(pos);
        req.word_in  = word;
        return req;
    endfunction

    function automatic void put_word(input int at, input logic signed [31:0] word,
                                     inout t_rsp rsp);
        if (list_words.size() >= LIST_CAP) begin
            rsp.full_reject = 1'b1;
        end else begin
            list_words.insert(at, word);
            rsp.applied = 1'b1;
        end
    endfunction

    function automatic t_rsp apply_to_list(input t_req req);
        t_rsp rsp;
        int pos;
        int len;
        rsp = '0;
        pos = $signed(req.position);
        len = list_words.size();
        case (req.op)
            OP_READ: begin
                if (pos >= 0 && pos < len) begin
                    rsp.read_word = list_words[pos];
                    rsp.found     = 1'b1;
                end else begin
                    rsp.read_word = MISSING_WORD;
                end
            end
            OP_INS_HEAD: put_word(0, req.word_in, rsp);
            OP_APPEND:   put_word(len, req.word_in, rsp);
            OP_INS_POS: begin
                if (pos <= len)
                    put_word(pos < 0 ? 0 : pos, req.word_in, rsp);
            end
            OP_DELETE: begin
                if (pos >= 0 && pos < len) begin
                    list_words.delete(pos);
                    rsp.applied = 1'b1;
                end
            end
            default: ;
        endcase
        rsp.length_now = 11'(list_words.size());
        return rsp;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_rsp(input t_rsp got);
        t_rsp want;
        if (rsp_due.size() == 0) begin
            report_mismatch("response beat with no request outstanding");
            return;
        end
        want = rsp_due.pop_front();
        if (got.read_word !== want.read_word)
            report_mismatch($sformatf("read_word %0d, want %0d",
                                      got.read_word, want.read_word));
        if (got.found !== want.found)
            report_mismatch($sformatf("found %b, want %b", got.found, want.found));
        if (got.applied !== want.applied)
            report_mismatch($sformatf("applied %b, want %b", got.applied, want.applied));
        if (got.full_reject !== want.full_reject)
            report_mismatch($sformatf("full_reject %b, want %b",
                                      got.full_reject, want.full_reject));
        if (got.length_now !== want.length_now)
            report_mismatch($sformatf("length_now %0d, want %0d",
                                      got.length_now, want.length_now));
    endtask

    // receiver: check each beat, then stall for a freshly drawn number of cycles
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                check_rsp(o_rsp);
                rx_hold = draw_wait();
            end
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_stall <= 1'b1;
                rx_hold--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_req(input t_req req);
        int gap;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        rsp_due.push_back(apply_to_list(req));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (rsp_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_list();
        logic [2:0] op;
        send_req(make_req(OP_READ, 0, 32'sd0));
        send_req(make_req(OP_READ, -1, 32'sd0));
        send_req(make_req(OP_READ, POS_MAX, 32'sd0));
        send_req(make_req(OP_READ, POS_MIN, 32'sd0));
        send_req(make_req(OP_DELETE, 0, 32'sd0));
        send_req(make_req(OP_INS_POS, 1, 32'sd7));
        for (op = OP_SPARE_FIRST; op != OP_SPARE_FIRST - 3'd1; op++) begin
            send_req(make_req(op, $urandom, $urandom));
            if (op == OP_SPARE_LAST)
                break;
        end
    endtask

    task automatic test_edit_ops();
        send_req(make_req(OP_INS_HEAD, 0, 32'sh7fff_ffff));
        send_req(make_req(OP_APPEND, 0, 32'sh8000_0000));
        send_req(make_req(OP_INS_POS, 1, -32'sd1));
        send_req(make_req(OP_INS_POS, 3, 32'sd0));
        send_req(make_req(OP_INS_POS, POS_MIN, 32'sh5555_aaaa));
        send_req(make_req(OP_INS_POS, POS_MAX, 32'sh1234_5678));
        send_req(make_req(OP_INS_POS, 6, 32'sh1234_5678));
        send_req(make_req(OP_READ, 0, 32'sd0));
        send_req(make_req(OP_READ, 2, 32'sd0));
        send_req(make_req(OP_READ, 4, 32'sd0));
        send_req(make_req(OP_READ, 5, 32'sd0));
        send_req(make_req(OP_READ, -1, 32'sd0));
        send_req(make_req(OP_DELETE, 2, 32'sd0));
        send_req(make_req(OP_DELETE, 3, 32'sd0));
        send_req(make_req(OP_DELETE, POS_MIN, 32'sd0));
        send_req(make_req(OP_DELETE, POS_MAX, 32'sd0));
        send_req(make_req(OP_DELETE, 3, 32'sd0));
        send_req(make_req(OP_READ, 0, 32'sd0));
        send_req(make_req(OP_READ, 2, 32'sd0));
    endtask

    task automatic test_full_list();
        int n;
        n = 0;
        while (list_words.size() < LIST_CAP) begin
            no_idle = (n < 400);
            send_req(make_req(OP_APPEND, 0, $urandom));
            n++;
        end
        no_idle = 1'b0;
        wait_drained();
        send_req(make_req(OP_INS_HEAD, 0, $urandom));
        send_req(make_req(OP_APPEND, 0, $urandom));
        send_req(make_req(OP_INS_POS, 0, $urandom));
        send_req(make_req(OP_INS_POS, LIST_CAP, $urandom));
        send_req(make_req(OP_INS_POS, -5, $urandom));
        send_req(make_req(OP_INS_POS, LIST_CAP + 1, $urandom));
        send_req(make_req(OP_READ, LIST_CAP - 1, 32'sd0));
        send_req(make_req(OP_READ, LIST_CAP, 32'sd0));
        send_req(make_req(OP_DELETE, 0, 32'sd0));
        send_req(make_req(OP_INS_POS, 7, $urandom));
        send_req(make_req(OP_DELETE, LIST_CAP, 32'sd0));
        send_req(make_req(OP_DELETE, LIST_CAP / 2, 32'sd0));
        send_req(make_req(OP_INS_HEAD, 0, $urandom));
        send_req(make_req(OP_READ, 0, 32'sd0));
        // empty it from the tail so nothing has to move
        while (list_words.size() > 0) begin
            no_idle = (list_words.size() % 256) < 128;
            if ($urandom_range(0, 7) == 0)
                send_req(make_req(OP_READ, $urandom_range(0, list_words.size() - 1),
                                  32'sd0));
            send_req(make_req(OP_DELETE, list_words.size() - 1, 32'sd0));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_ops(input int count);
        logic [2:0] op;
        int pos;
        int len;
        for (int k = 0; k < count; k++) begin
            len = list_words.size();
            if (k % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (k == count / 2)
                wait_drained();
            if ($urandom_range(0, 99) < 8)
                pos = $signed(16'($urandom));
            else
                pos = $urandom_range(0, len + 2) - 1;
            if ($urandom_range(0, 99) < 4) begin
                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            end else if ($urandom_range(0, 2) == 0) begin
                op = OP_READ;
            end else if ($urandom_range(0, 63) >= len) begin
                case ($urandom_range(0, 2))
                    0:       op = OP_INS_HEAD;
                    1:       op = OP_APPEND;
                    default: op = OP_INS_POS;
                endcase
            end else begin
                op = OP_DELETE;
            end
            send_req(make_req(op, pos, $urandom));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_edit_ops();
        wait_drained();
        test_full_list();
        test_random_ops(580);
        wait_drained();
        repeat (LIST_CAP + 16) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
